[hdl/rqe_pkg.sv]
package rqe_pkg;

  localparam int SYMBOL_W    = 8;
  localparam int ALPHA_W     = 9;
  localparam int GRAM_LEN_W  = 6;
  localparam int CODE_W      = 64;
  localparam int OUT_POS_W   = 32;
  localparam int CFG_INDEX_W = 8;
  localparam int QUEUE_DEPTH = 2;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_RADIX       = 8'd0,
    REG_GRAM_LENGTH = 8'd1,
    REG_TOP_WEIGHT  = 8'd2
  } rqe_reg_e;

  localparam logic [ALPHA_W-1:0]    ALPHA_RESET      = 9'd4;
  localparam logic [GRAM_LEN_W-1:0] GRAM_LEN_RESET   = 6'd8;
  localparam logic [CODE_W-1:0]     TOP_WEIGHT_RESET = 64'd16384;

  typedef struct packed {
    logic [ALPHA_W-1:0]    radix;
    logic [GRAM_LEN_W-1:0] gram_length;
    logic [CODE_W-1:0]     top_weight;
  } rqe_cfg_t;

  // classified request handed from front to back
  typedef struct packed {
    logic [SYMBOL_W-1:0] symbol;
    logic [SYMBOL_W-1:0] oldest;
    logic                emit;
    logic                last;
  } rqe_item_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_WEIGH,
    BK_ROLL
  } rqe_back_state_e;

endpackage

[hdl/rqe_if.sv]
interface rqe_sym_if;
  logic                         valid;
  logic                         ready;
  logic [rqe_pkg::SYMBOL_W-1:0] symbol;
  logic                         last_of_sequence;

  modport source (output valid, symbol, last_of_sequence, input ready);
  modport sink (input valid, symbol, last_of_sequence, output ready);
endinterface

interface rqe_gram_if;
  logic                          valid;
  logic                          ready;
  logic [rqe_pkg::CODE_W-1:0]    gram_code;
  logic [rqe_pkg::OUT_POS_W-1:0] start_position;

  modport source (output valid, gram_code, start_position, input ready);
  modport sink (input valid, gram_code, start_position, output ready);
endinterface

interface rqe_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [rqe_pkg::CFG_INDEX_W-1:0] index;
  logic [rqe_pkg::CODE_W-1:0]      data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

[hdl/rqe_front.sv]
module rqe_front #(
  parameter int MAX_Q         = 32,
  parameter int POSITION_BITS = 32
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               sym_valid,
  input  logic [rqe_pkg::SYMBOL_W-1:0]       symbol,
  input  logic                               last_of_sequence,
  output logic                               sym_ready,
  input  logic [rqe_pkg::GRAM_LEN_W-1:0]     gram_length,
  input  logic                               queue_ready,
  output logic                               push,
  output rqe_pkg::rqe_item_t                 push_item,
  output logic [POSITION_BITS-1:0]           push_pos
);

  localparam int QW = $clog2(MAX_Q + 1);
  localparam int IW = (MAX_Q > 1) ? $clog2(MAX_Q) : 1;

  logic [rqe_pkg::SYMBOL_W-1:0] window [MAX_Q];
  logic [QW-1:0]                seen;
  logic [POSITION_BITS-1:0]     next_position;

  logic [6:0]                   gl_wide;
  logic [QW-1:0]                q_eff;
  logic [QW-1:0]                q_m1;
  logic                         full;
  logic                         emit;
  logic [QW-1:0]                seen_inc;

  always_comb begin
    gl_wide = {1'b0, gram_length};
    if (gl_wide == 7'd0) begin
      q_eff = QW'(1);
    end else if (gl_wide > 7'(MAX_Q)) begin
      q_eff = QW'(MAX_Q);
    end else begin
      q_eff = gl_wide[QW-1:0];
    end
    q_m1     = q_eff - QW'(1);
    full     = (seen >= q_eff);
    seen_inc = seen + QW'(1);
    emit     = full || (seen_inc == q_eff);
  end

  assign sym_ready = queue_ready;
  assign push      = sym_valid && queue_ready;

  always_comb begin
    push_item.symbol = symbol;
    push_item.oldest = full ? window[q_m1[IW-1:0]] : '0;
    push_item.emit   = emit;
    push_item.last   = last_of_sequence;
    push_pos         = next_position;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      seen          <= '0;
      next_position <= '0;
      for (int k = 0; k < MAX_Q; k++) begin
        window[k] <= '0;
      end
    end else if (push) begin
      if (last_of_sequence) begin
        seen          <= '0;
        next_position <= '0;
        for (int k = 0; k < MAX_Q; k++) begin
          window[k] <= '0;
        end
      end else begin
        seen <= full ? q_eff : seen_inc;
        if (emit) begin
          next_position <= next_position + POSITION_BITS'(1);
        end
        window[0] <= symbol;
        for (int k = 1; k < MAX_Q; k++) begin
          window[k] <= window[k-1];
        end
      end
    end
  end

endmodule

[hdl/rqe_queue.sv]
module rqe_queue #(
  parameter int WIDTH = 18,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             not_full,
  input  logic             pop,
  output logic [WIDTH-1:0] pop_data,
  output logic             not_empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slots [DEPTH];
  logic [PW-1:0]    wr_ptr;
  logic [PW-1:0]    rd_ptr;
  logic [CW-1:0]    count;

  assign not_full  = (count != CW'(DEPTH));
  assign not_empty = (count != '0);
  assign pop_data  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      end
      if (push && !pop) begin
        count <= count + CW'(1);
      end else if (pop && !push) begin
        count <= count - CW'(1);
      end
    end
  end

endmodule

[hdl/rqe_back.sv]
module rqe_back #(
  parameter int POSITION_BITS = 32
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             item_valid,
  input  rqe_pkg::rqe_item_t               queue_item,
  input  logic [POSITION_BITS-1:0]         queue_pos,
  output logic                             pop,
  input  rqe_pkg::rqe_cfg_t                cfg,
  output logic                             gram_valid,
  input  logic                             gram_ready,
  output logic [rqe_pkg::CODE_W-1:0]       gram_code,
  output logic [rqe_pkg::OUT_POS_W-1:0]    gram_pos
);

  localparam int WIDE_POS_W = (POSITION_BITS > rqe_pkg::OUT_POS_W) ?
                              POSITION_BITS : rqe_pkg::OUT_POS_W;

  rqe_pkg::rqe_back_state_e state;
  rqe_pkg::rqe_back_state_e state_next;

  rqe_pkg::rqe_item_t             item;
  logic [POSITION_BITS-1:0]       pos;
  logic [rqe_pkg::CODE_W-1:0]     code;
  logic [rqe_pkg::CODE_W-1:0]     prod;

  logic                           commit;
  logic [rqe_pkg::CODE_W-1:0]     roll_code;
  logic [WIDE_POS_W-1:0]          pos_wide;

  always_comb begin
    state_next = state;
    case (state)
      rqe_pkg::BK_IDLE: begin
        if (item_valid) begin
          state_next = rqe_pkg::BK_WEIGH;
        end
      end
      rqe_pkg::BK_WEIGH: begin
        state_next = rqe_pkg::BK_ROLL;
      end
      rqe_pkg::BK_ROLL: begin
        if (commit) begin
          state_next = rqe_pkg::BK_IDLE;
        end
      end
      default: begin
        state_next = rqe_pkg::BK_IDLE;
      end
    endcase
  end

  always_comb begin
    pop    = 1'b0;
    commit = 1'b0;
    case (state)
      rqe_pkg::BK_IDLE: begin
        pop = item_valid;
      end
      rqe_pkg::BK_ROLL: begin
        commit = !item.emit || !gram_valid || gram_ready;
      end
      default: begin
        pop    = 1'b0;
        commit = 1'b0;
      end
    endcase
  end

  // drop oldest weight, shift up one digit, add new symbol
  assign roll_code = (code - prod) * rqe_pkg::CODE_W'(cfg.radix)
                     + rqe_pkg::CODE_W'(item.symbol);
  assign pos_wide  = WIDE_POS_W'(pos);

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= rqe_pkg::BK_IDLE;
      code       <= '0;
      gram_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (commit && item.emit) begin
        gram_valid <= 1'b1;
      end else if (gram_ready) begin
        gram_valid <= 1'b0;
      end
      if (commit) begin
        code <= item.last ? '0 : roll_code;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      item <= queue_item;
      pos  <= queue_pos;
    end
    if (state == rqe_pkg::BK_WEIGH) begin
      prod <= cfg.top_weight * rqe_pkg::CODE_W'(item.oldest);
    end
    if (commit && item.emit) begin
      gram_code <= roll_code;
      gram_pos  <= pos_wide[rqe_pkg::OUT_POS_W-1:0];
    end
  end

endmodule

[hdl/rolling_qgram_encoder.sv]
// an accepted request waits in a 2-entry queue, which lets the front take up to
// two requests ahead of the back end; the back end pops one only when idle,
// weighs its oldest symbol, then rolls its 64-bit code register and registers
// the result, holding in roll while the output is stalled
// reset: synchronous, active high; clears window, code, counters, queue and
// output valid, and loads the register defaults
module rolling_qgram_encoder #(
  parameter int MAX_Q         = 32,
  parameter int POSITION_BITS = 32
) (
  input  logic      clk,
  input  logic      rst,
  rqe_sym_if.sink   symbols,
  rqe_gram_if.source grams,
  rqe_cfg_if.sink   cfg
);

  localparam int ITEM_W  = $bits(rqe_pkg::rqe_item_t);
  localparam int ENTRY_W = ITEM_W + POSITION_BITS;

  rqe_pkg::rqe_cfg_t  regs;

  logic                      queue_ready;
  logic                      push;
  rqe_pkg::rqe_item_t        push_item;
  logic [POSITION_BITS-1:0]  push_pos;
  logic                      pop;
  logic                      queue_valid;
  logic [ENTRY_W-1:0]        pop_data;
  rqe_pkg::rqe_item_t        pop_item;
  logic [POSITION_BITS-1:0]  pop_pos;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.radix       <= rqe_pkg::ALPHA_RESET;
      regs.gram_length <= rqe_pkg::GRAM_LEN_RESET;
      regs.top_weight  <= rqe_pkg::TOP_WEIGHT_RESET;
    end else if (cfg.valid) begin
      case (cfg.index)
        rqe_pkg::REG_RADIX: begin
          regs.radix <= cfg.data[rqe_pkg::ALPHA_W-1:0];
        end
        rqe_pkg::REG_GRAM_LENGTH: begin
          regs.gram_length <= cfg.data[rqe_pkg::GRAM_LEN_W-1:0];
        end
        rqe_pkg::REG_TOP_WEIGHT: begin
          regs.top_weight <= cfg.data;
        end
        default: begin
          regs <= regs;
        end
      endcase
    end
  end

  rqe_front #(
    .MAX_Q         (MAX_Q),
    .POSITION_BITS (POSITION_BITS)
  ) u_front (
    .clk              (clk),
    .rst              (rst),
    .sym_valid        (symbols.valid),
    .symbol           (symbols.symbol),
    .last_of_sequence (symbols.last_of_sequence),
    .sym_ready        (symbols.ready),
    .gram_length      (regs.gram_length),
    .queue_ready      (queue_ready),
    .push             (push),
    .push_item        (push_item),
    .push_pos         (push_pos)
  );

  rqe_queue #(
    .WIDTH (ENTRY_W),
    .DEPTH (rqe_pkg::QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data ({push_pos, push_item}),
    .not_full  (queue_ready),
    .pop       (pop),
    .pop_data  (pop_data),
    .not_empty (queue_valid)
  );

  assign pop_item = pop_data[ITEM_W-1:0];
  assign pop_pos  = pop_data[ENTRY_W-1:ITEM_W];

  rqe_back #(
    .POSITION_BITS (POSITION_BITS)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .item_valid (queue_valid),
    .queue_item (pop_item),
    .queue_pos  (pop_pos),
    .pop        (pop),
    .cfg        (regs),
    .gram_valid (grams.valid),
    .gram_ready (grams.ready),
    .gram_code  (grams.gram_code),
    .gram_pos   (grams.start_position)
  );

endmodule

[hdl/rqe_checker.sv]
module rqe_checker (
  input logic                              clk,
  input logic                              rst,
  input logic                              sym_valid,
  input logic                              sym_ready,
  input logic                              gram_valid,
  input logic                              gram_ready,
  input logic [rqe_pkg::CODE_W-1:0]        gram_code,
  input logic [rqe_pkg::OUT_POS_W-1:0]     start_position,
  input logic                              cfg_ready
);

  // result stays offered until taken
  assert property (@(posedge clk) disable iff (rst)
    gram_valid && !gram_ready |=> gram_valid)
    else $error("result dropped while stalled");

  assert property (@(posedge clk) disable iff (rst)
    gram_valid && !gram_ready |=> $stable(gram_code) && $stable(start_position))
    else $error("result payload changed while stalled");

  // reset empties the queue and the output register
  assert property (@(posedge clk)
    rst |=> !gram_valid && sym_ready)
    else $error("block not empty after reset");

  // the queue only fills through an accepted request
  assert property (@(posedge clk) disable iff (rst)
    $fell(sym_ready) |-> $past(sym_valid))
    else $error("input ready dropped with no request");

  assert property (@(posedge clk) disable iff (rst)
    cfg_ready)
    else $error("register port not ready");

endmodule

bind rolling_qgram_encoder rqe_checker u_rqe_checker (
  .clk            (clk),
  .rst            (rst),
  .sym_valid      (symbols.valid),
  .sym_ready      (symbols.ready),
  .gram_valid     (grams.valid),
  .gram_ready     (grams.ready),
  .gram_code      (grams.gram_code),
  .start_position (grams.start_position),
  .cfg_ready      (cfg.ready)
);

[tb/tb_top.sv]
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int GRAM_MAX = 32;
  localparam int DRAIN_CYCLES = 20;
  localparam int RUN_LIMIT = 500000;
  localparam int REQUEST_TARGET = 1400;
  localparam int STALL_CYCLES = 200;
  localparam logic [rqe_pkg::CFG_INDEX_W-1:0] REG_UNUSED_LOW = 8'd3;
  localparam logic [rqe_pkg::CFG_INDEX_W-1:0] REG_UNUSED_TOP = 8'hFF;

  typedef struct packed {
    logic [rqe_pkg::SYMBOL_W-1:0] symbol;
    logic                         last_of_sequence;
  } sym_req_t;

  typedef struct packed {
    logic [rqe_pkg::CODE_W-1:0]    gram_code;
    logic [rqe_pkg::OUT_POS_W-1:0] start_position;
  } gram_t;

  logic clk = 1'b0;
  logic rst;

  rqe_sym_if  sym_bus();
  rqe_gram_if gram_bus();
  rqe_cfg_if  cfg_bus();

  rolling_qgram_encoder #(
    .MAX_Q(GRAM_MAX),
    .POSITION_BITS(32)
  ) i_dut (
    .clk(clk),
    .rst(rst),
    .symbols(sym_bus),
    .grams(gram_bus),
    .cfg(cfg_bus)
  );

  always #1 clk = ~clk;

  // register copies
  logic [rqe_pkg::ALPHA_W-1:0]    alpha_cfg = rqe_pkg::ALPHA_RESET;
  logic [rqe_pkg::GRAM_LEN_W-1:0] gram_cfg = rqe_pkg::GRAM_LEN_RESET;
  logic [rqe_pkg::CODE_W-1:0]     weight_cfg = rqe_pkg::TOP_WEIGHT_RESET;

  // sequence state
  logic [rqe_pkg::SYMBOL_W-1:0]  recent_symbols [GRAM_MAX];
  logic [rqe_pkg::CODE_W-1:0]    rolling_code;
  int                            window_fill;
  logic [rqe_pkg::OUT_POS_W-1:0] next_start;

  sym_req_t pending[$];
  gram_t    grams_due[$];

  int mismatches;
  int queued_total;
  int requests_taken;
  int cycle_count;
  int stall_left;
  int stalls_taken;
  int sym_wait;
  int gram_wait;
  bit sym_busy;
  bit gram_busy;

  function automatic int active_length(input logic [rqe_pkg::GRAM_LEN_W-1:0] q);
    if (q == 0) return 1;
    if (q > GRAM_MAX) return GRAM_MAX;
    return q;
  endfunction

  function automatic logic [rqe_pkg::CODE_W-1:0] alpha_power(
      input logic [rqe_pkg::ALPHA_W-1:0] a, input logic [rqe_pkg::GRAM_LEN_W-1:0] q);
    logic [rqe_pkg::CODE_W-1:0] p;
    p = 64'd1;
    for (int k = 1; k < active_length(q); k++) p = p * a;
    return p;
  endfunction

  function automatic void clear_sequence();
    foreach (recent_symbols[k]) recent_symbols[k] = '0;
    rolling_code = '0;
    window_fill = 0;
    next_start = '0;
  endfunction

  function automatic void predict_gram(input logic [rqe_pkg::SYMBOL_W-1:0] s,
                                       input logic last);
    int q;
    logic [rqe_pkg::CODE_W-1:0] oldest;
    bit emit;
    q = active_length(gram_cfg);
    emit = 1'b0;
    if (window_fill >= q) begin
      oldest = recent_symbols[q-1];
      rolling_code = (rolling_code - oldest * weight_cfg) * alpha_cfg + s;
      window_fill = q;
      emit = 1'b1;
    end else begin
      rolling_code = rolling_code * alpha_cfg + s;
      window_fill++;
      emit = (window_fill == q);
    end
    for (int k = GRAM_MAX - 1; k > 0; k--) recent_symbols[k] = recent_symbols[k-1];
    recent_symbols[0] = s;
    if (emit) begin
      grams_due.push_back('{gram_code: rolling_code, start_position: next_start});
      next_start++;
    end
    if (last) clear_sequence();
  endfunction

  task automatic report_mismatch(input string what, input logic [rqe_pkg::CODE_W-1:0] got,
                                 input logic [rqe_pkg::CODE_W-1:0] want);
    $display("mismatch at %0t: %s got %h want %h", $realtime, what, got, want);
    mismatches++;
  endtask

  function automatic logic [rqe_pkg::SYMBOL_W-1:0] pick_symbol();
    if (alpha_cfg > 1 && alpha_cfg <= 256 && $urandom_range(0, 15) != 0)
      return rqe_pkg::SYMBOL_W'($urandom_range(0, alpha_cfg - 1));
    return rqe_pkg::SYMBOL_W'($urandom_range(0, 255));
  endfunction

  function automatic void queue_symbol(input logic [rqe_pkg::SYMBOL_W-1:0] s,
                                       input logic last);
    pending.push_back('{symbol: s, last_of_sequence: last});
    queued_total++;
  endfunction

  // mostly sequences a little longer than q, some short or long ones
  function automatic void queue_requests(input int count);
    int q;
    int len;
    q = active_length(gram_cfg);
    while (count > 0) begin
      case ($urandom_range(0, 7))
        0: len = $urandom_range(1, q);
        1: len = q + $urandom_range(40, 120);
        default: len = q + $urandom_range(0, 12);
      endcase
      if (len > count) len = count;
      for (int k = 0; k < len; k++)
        queue_symbol(pick_symbol(), k == len - 1 && $urandom_range(0, 5) != 0);
      count -= len;
    end
  endfunction

  task automatic wait_idle();
    do @(negedge clk);
    while (pending.size() != 0 || sym_bus.valid || grams_due.size() != 0);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic [rqe_pkg::CFG_INDEX_W-1:0] index,
                           input logic [rqe_pkg::CODE_W-1:0] value);
    @(posedge clk);
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= index;
    cfg_bus.data <= value;
    do @(posedge clk);
    while (!cfg_bus.ready);
    cfg_bus.valid <= 1'b0;
    case (index)
      rqe_pkg::REG_RADIX:       alpha_cfg = value[rqe_pkg::ALPHA_W-1:0];
      rqe_pkg::REG_GRAM_LENGTH: gram_cfg = value[rqe_pkg::GRAM_LEN_W-1:0];
      rqe_pkg::REG_TOP_WEIGHT:  weight_cfg = value;
      default: ;
    endcase
  endtask

  task automatic run_phase(input logic [rqe_pkg::ALPHA_W-1:0] alpha,
                           input logic [rqe_pkg::GRAM_LEN_W-1:0] q,
                           input logic [rqe_pkg::CODE_W-1:0] weight, input int count);
    logic [rqe_pkg::CODE_W-1:0] noise;
    wait_idle();
    noise = {$urandom, $urandom};
    write_reg(rqe_pkg::REG_RADIX, {noise[rqe_pkg::CODE_W-1:rqe_pkg::ALPHA_W], alpha});
    noise = {$urandom, $urandom};
    write_reg(rqe_pkg::REG_GRAM_LENGTH,
              {noise[rqe_pkg::CODE_W-1:rqe_pkg::GRAM_LEN_W], q});
    write_reg(rqe_pkg::REG_TOP_WEIGHT, weight);
    @(negedge clk);
    queue_requests(count);
  endtask

  // symbol driver
  always @(posedge clk) begin
    if (rst) begin
      sym_bus.valid <= 1'b0;
      sym_wait = 0;
    end else begin : sym_driver
      sym_req_t next_req;
      if (sym_bus.valid && sym_bus.ready) begin
        predict_gram(sym_bus.symbol, sym_bus.last_of_sequence);
        requests_taken <= requests_taken + 1;
        if ($urandom_range(0, 39) == 0) sym_busy = !sym_busy;
        sym_wait = sym_busy ? $urandom_range(0, 18) : 0;
      end
      if (!sym_bus.valid || sym_bus.ready) begin
        if (sym_wait != 0) begin
          sym_wait--;
          sym_bus.valid <= 1'b0;
        end else if (pending.size() != 0) begin
          next_req = pending.pop_front();
          sym_bus.valid <= 1'b1;
          sym_bus.symbol <= next_req.symbol;
          sym_bus.last_of_sequence <= next_req.last_of_sequence;
        end else begin
          sym_bus.valid <= 1'b0;
        end
      end
    end
  end

  // long receiver hold-off so the block backs up into its input
  always @(posedge clk) begin
    if (rst) begin
      stall_left <= 0;
      stalls_taken <= 0;
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
    end else if (stalls_taken < 2 && requests_taken >= 300 + 600 * stalls_taken) begin
      stall_left <= STALL_CYCLES;
      stalls_taken <= stalls_taken + 1;
    end
  end

  // gram monitor
  always @(posedge clk) begin
    if (rst) begin
      gram_bus.ready <= 1'b0;
      gram_wait = 0;
    end else begin : gram_monitor
      gram_t due;
      if (gram_bus.valid && gram_bus.ready) begin
        if (grams_due.size() == 0) begin
          report_mismatch("gram with no request pending", gram_bus.gram_code, '0);
        end else begin
          due = grams_due.pop_front();
          if (gram_bus.gram_code !== due.gram_code)
            report_mismatch("gram_code", gram_bus.gram_code, due.gram_code);
          if (gram_bus.start_position !== due.start_position)
            report_mismatch("start_position", gram_bus.start_position, due.start_position);
        end
        if ($urandom_range(0, 39) == 0) gram_busy = !gram_busy;
        gram_wait = gram_busy ? $urandom_range(0, 18) : 0;
      end
      if (stall_left != 0) begin
        gram_bus.ready <= 1'b0;
      end else if (gram_wait != 0) begin
        gram_wait--;
        gram_bus.ready <= 1'b0;
      end else begin
        gram_bus.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == RUN_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  initial begin : stimulus
    logic [rqe_pkg::SYMBOL_W-1:0]   opening [22];
    logic [rqe_pkg::ALPHA_W-1:0]    alpha;
    logic [rqe_pkg::GRAM_LEN_W-1:0] q;
    logic [rqe_pkg::CODE_W-1:0]     weight;
    rst = 1'b1;
    sym_bus.valid = 1'b0;
    sym_bus.symbol = '0;
    sym_bus.last_of_sequence = 1'b0;
    gram_bus.ready = 1'b0;
    cfg_bus.valid = 1'b0;
    cfg_bus.index = '0;
    cfg_bus.data = '0;
    mismatches = 0;
    queued_total = 0;
    requests_taken = 0;
    cycle_count = 0;
    sym_busy = 1'b0;
    gram_busy = 1'b1;
    clear_sequence();
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // reset settings: full sequence, one shorter than q, then out-of-alphabet symbols
    opening = '{8'd3, 8'd0, 8'd1, 8'd2, 8'd3, 8'd3, 8'd0, 8'd1, 8'd2, 8'd3,
                8'd2, 8'd1, 8'd3,
                8'd255, 8'd128, 8'd0, 8'd255, 8'd127, 8'd4, 8'd255, 8'd1, 8'd254};
    foreach (opening[k]) queue_symbol(opening[k], k == 9 || k == 12);

    // writes to unknown registers are dropped, sequence carries on
    wait_idle();
    write_reg(REG_UNUSED_LOW, {$urandom, $urandom});
    write_reg(REG_UNUSED_TOP, '1);
    @(negedge clk);
    queue_requests(60);

    run_phase(9'd256, 6'd1, 64'd1, 80);
    run_phase(9'd256, 6'd32, alpha_power(9'd256, 6'd32), 60);
    run_phase(9'd1, 6'd32, 64'd1, 80);
    run_phase(9'd4, 6'd45, alpha_power(9'd4, 6'd45), 80);
    run_phase(9'd3, 6'd63, alpha_power(9'd3, 6'd63), 60);
    run_phase(9'd10, 6'd0, 64'd1, 60);
    run_phase(9'd0, 6'd5, 64'd0, 60);
    run_phase(9'd511, 6'd7, alpha_power(9'd511, 6'd7), 60);
    run_phase(9'd20, 6'd6, '1, 60);
    run_phase(9'd2, 6'd3, {$urandom, $urandom}, 60);

    while (queued_total < REQUEST_TARGET) begin
      case ($urandom_range(0, 5))
        0: alpha = 9'd256;
        1: alpha = 9'd1;
        default: alpha = rqe_pkg::ALPHA_W'($urandom_range(2, 255));
      endcase
      q = rqe_pkg::GRAM_LEN_W'($urandom_range(1, GRAM_MAX));
      weight = ($urandom_range(0, 5) == 0) ? {$urandom, $urandom} : alpha_power(alpha, q);
      run_phase(alpha, q, weight, $urandom_range(60, 140));
    end

    wait_idle();
    if (mismatches == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

endmodule
